// File: hdl/lre_pkg.sv
// Package for the range encoder: command codes, result item type, shared constants.
// Used by lre_front, lre_back and the top level; depends on nothing.
`default_nettype none

package lre_pkg;

    // Default values for the top-level parameters
    localparam int PROB_BITS_DEF       = 11;
    localparam int MAX_DIRECT_BITS_DEF = 26;

    // Fixed field widths of the item ports
    localparam int CMD_W     = 2;
    localparam int PROB_IN_W = 11;
    localparam int DIR_W     = 26;
    localparam int NUM_IN_W  = 5;

    // Internal widths
    localparam int DIR_EXT_W = 32;   // direct bits as seen by the engine
    localparam int IDX_W     = 5;    // bit index into DIR_EXT_W
    localparam int CMP_W     = 16;   // compare width for probability clamp
    localparam int NCMP_W    = 6;    // compare width for bit-count clamp

    // Queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    // Encoder constants
    localparam logic [31:0] RANGE_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] PEND_MAX     = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_FF      = 8'hFF;
    localparam int          FLUSH_STEPS  = 5;
    localparam int          STEP_W       = 3;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_BIT    = 2'd0,
        CMD_DIRECT = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [7:0]  first_byte;
        logic [31:0] run_length;
        logic [7:0]  run_byte;
        logic        last;
    } res_t;

    // Width of the clamped bit count
    function automatic int n_width(input int max_bits);
        return $clog2(max_bits + 1);
    endfunction

    // Width of one command queue entry: cmd, bit, prob, direct bits, count
    function automatic int entry_width(input int prob_bits, input int max_bits);
        return CMD_W + 1 + prob_bits + DIR_W + n_width(max_bits);
    endfunction

endpackage

`default_nettype wire

// File: hdl/lre_fifo.sv
// Small synchronous FIFO with full/empty flags and a combinational head read.
// Standalone; used for the command queue and the result queue.
`default_nettype none

module lre_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lre_front.sv
// Front end: takes input items, clamps their fields, drops no-op commands
// and queues the rest. Depends on lre_pkg and lre_fifo.
`default_nettype none

module lre_front
    import lre_pkg::*;
#(
    parameter int PROB_BITS       = PROB_BITS_DEF,
    parameter int MAX_DIRECT_BITS = MAX_DIRECT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic                  bit_value,
    input  wire logic [PROB_IN_W-1:0]  prob,
    input  wire logic [DIR_W-1:0]      direct_bits,
    input  wire logic [NUM_IN_W-1:0]   dir_count,
    input  wire logic                  q_pop,
    output logic                       q_empty,
    output logic [entry_width(PROB_BITS, MAX_DIRECT_BITS)-1:0] q_data
);

    localparam int ENTRY_W = entry_width(PROB_BITS, MAX_DIRECT_BITS);
    localparam int N_W     = n_width(MAX_DIRECT_BITS);
    localparam logic [CMP_W-1:0]  PROB_MAX = CMP_W'((1 << PROB_BITS) - 1);
    localparam logic [NCMP_W-1:0] NUM_MAX  = NCMP_W'(MAX_DIRECT_BITS);

    logic [CMP_W-1:0]   prob_ext;
    logic [CMP_W-1:0]   prob_clamp;
    logic [NCMP_W-1:0]  num_ext;
    logic [NCMP_W-1:0]  num_clamp;
    logic               keep;
    logic [ENTRY_W-1:0] entry;

    // clamp probability into 1 .. 2^PROB_BITS-1
    always_comb
    begin
        prob_ext = CMP_W'(prob);
        if (prob_ext == '0)
        begin
            prob_clamp = CMP_W'(1);
        end
        else if (prob_ext > PROB_MAX)
        begin
            prob_clamp = PROB_MAX;
        end
        else
        begin
            prob_clamp = prob_ext;
        end
    end

    // clamp bit count to the direct-bit limit
    always_comb
    begin
        num_ext   = NCMP_W'(dir_count);
        num_clamp = (num_ext > NUM_MAX) ? NUM_MAX : num_ext;
    end

    // only commands that do something go into the queue
    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_BIT:    keep = 1'b1;
            CMD_DIRECT: keep = (num_ext != '0);
            CMD_FLUSH:  keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign entry = {cmd, bit_value, PROB_BITS'(prob_clamp), direct_bits, N_W'(num_clamp)};

    lre_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

endmodule

`default_nettype wire

// File: hdl/lre_back.sv
// Back end: range coder engine (uses lre_pkg). Runs one queued command at a
// time and writes result items; one byte shift per cycle unless results stall.
`default_nettype none

module lre_back
    import lre_pkg::*;
#(
    parameter int PROB_BITS       = PROB_BITS_DEF,
    parameter int MAX_DIRECT_BITS = MAX_DIRECT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire logic [entry_width(PROB_BITS, MAX_DIRECT_BITS)-1:0] q_data,
    output logic       q_pop,
    input  wire logic  res_full,
    output logic       res_push,
    output res_t       res_data
);

    localparam int ENTRY_W = entry_width(PROB_BITS, MAX_DIRECT_BITS);
    localparam int N_W     = n_width(MAX_DIRECT_BITS);
    localparam int RS_W    = 32 - PROB_BITS;
    localparam logic [STEP_W-1:0] FLUSH_LAST = STEP_W'(FLUSH_STEPS - 1);
    localparam logic [N_W-1:0]    N_ONE      = N_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_NORM,
        S_DIR,
        S_FLUSH,
        S_END
    } state_t;

    // queue head fields
    cmd_t                 e_cmd;
    logic                 e_bit;
    logic [PROB_BITS-1:0] e_prob;
    logic [DIR_W-1:0]     e_dir;
    logic [N_W-1:0]       e_n;

    assign e_cmd  = cmd_t'(q_data[ENTRY_W-1 -: CMD_W]);
    assign e_bit  = q_data[ENTRY_W-CMD_W-1];
    assign e_prob = q_data[N_W+DIR_W +: PROB_BITS];
    assign e_dir  = q_data[N_W +: DIR_W];
    assign e_n    = q_data[N_W-1:0];

    // coder state
    state_t               state_reg, state_next;
    logic [32:0]          low_reg, low_next;
    logic [31:0]          range_reg, range_next;
    logic [7:0]           cache_reg, cache_next;
    logic [31:0]          pend_reg, pend_next;
    logic                 held_vld_reg, held_vld_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    // per-item working values
    res_t                 held_reg, held_next;
    logic [31:0]          bound_reg, bound_next;
    logic                 bit_reg, bit_next;
    logic [DIR_EXT_W-1:0] dir_reg, dir_next;
    logic [N_W-1:0]       n_reg, n_next;

    // bound = (range >> PROB_BITS) * prob
    logic [RS_W-1:0] range_hi;
    logic [31:0]     mul;

    assign range_hi = range_reg[31:PROB_BITS];
    assign mul      = 32'(range_hi) * 32'(e_prob);

    // direct bit: halve range, add to low when the bit is set
    logic [IDX_W-1:0] dir_idx;
    logic [31:0]      dir_range;
    logic [32:0]      dir_low;
    logic             dir_shift;

    assign dir_idx   = IDX_W'(n_reg - 1'b1);
    assign dir_range = {1'b0, range_reg[31:1]};
    assign dir_low   = dir_reg[dir_idx] ? (low_reg + {1'b0, dir_range}) : low_reg;
    assign dir_shift = (dir_range[31:24] == 8'h00);

    // modeled bit update
    logic [32:0] upd_low;
    logic [31:0] upd_range;

    assign upd_low   = bit_reg ? (low_reg + {1'b0, bound_reg}) : low_reg;
    assign upd_range = bit_reg ? (range_reg - bound_reg) : bound_reg;

    // one byte shift of low, with carry and pending run
    logic [32:0] sh_low;
    logic        sh_carry;
    logic        sh_rel;
    res_t        sh_res;
    logic [32:0] sh_low_new;
    logic [7:0]  sh_cache_new;
    logic [31:0] sh_pend_new;

    assign sh_low = (state_reg == S_DIR) ? dir_low : low_reg;

    always_comb
    begin
        sh_carry            = sh_low[32];
        sh_rel              = (sh_low[31:24] != BYTE_FF) || sh_carry;
        sh_res.first_byte   = cache_reg + {7'd0, sh_carry};
        sh_res.run_length   = pend_reg - 1'b1;
        sh_res.run_byte     = sh_carry ? 8'h00 : BYTE_FF;
        sh_res.last         = 1'b0;
        sh_low_new          = {1'b0, sh_low[23:0], 8'h00};
        if (sh_rel)
        begin
            sh_cache_new = sh_low[31:24];
            sh_pend_new  = 32'd1;
        end
        else
        begin
            sh_cache_new = cache_reg;
            sh_pend_new  = (pend_reg == PEND_MAX) ? pend_reg : pend_reg + 1'b1;
        end
    end

    // step control: shifting states share the result handling
    logic        st_active;
    logic        st_shift;
    logic        st_final;
    logic [31:0] st_range;
    logic [32:0] st_low_keep;
    logic        st_out;
    logic        need_push;

    always_comb
    begin
        st_active   = 1'b0;
        st_shift    = 1'b0;
        st_final    = 1'b0;
        st_range    = range_reg;
        st_low_keep = low_reg;
        case (state_reg)
            S_NORM:
            begin
                st_active = 1'b1;
                st_shift  = 1'b1;
                st_range  = {range_reg[23:0], 8'h00};
                st_final  = (st_range[31:24] != 8'h00);
            end
            S_DIR:
            begin
                st_active   = 1'b1;
                st_shift    = dir_shift;
                st_range    = dir_shift ? {dir_range[23:0], 8'h00} : dir_range;
                st_final    = (n_reg == N_ONE);
                st_low_keep = dir_low;
            end
            S_FLUSH:
            begin
                st_active = 1'b1;
                st_shift  = 1'b1;
                st_final  = (step_reg == FLUSH_LAST);
            end
            default:
            begin
                st_active = 1'b0;
            end
        endcase
        st_out    = st_shift && sh_rel;
        need_push = held_vld_reg && (st_out || st_final);
    end

    // main sequencer
    always_comb
    begin
        state_next    = state_reg;
        low_next      = low_reg;
        range_next    = range_reg;
        cache_next    = cache_reg;
        pend_next     = pend_reg;
        held_vld_next = held_vld_reg;
        step_next     = step_reg;
        held_next     = held_reg;
        bound_next    = bound_reg;
        bit_next      = bit_reg;
        dir_next      = dir_reg;
        n_next        = n_reg;
        q_pop         = 1'b0;
        res_push      = 1'b0;
        res_data      = held_reg;
        res_data.last = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (e_cmd)
                        CMD_BIT:
                        begin
                            bit_next   = e_bit;
                            bound_next = mul;
                            state_next = S_UPD;
                        end
                        CMD_DIRECT:
                        begin
                            dir_next   = DIR_EXT_W'(e_dir);
                            n_next     = e_n;
                            state_next = S_DIR;
                        end
                        CMD_FLUSH:
                        begin
                            step_next  = '0;
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                low_next   = upd_low;
                range_next = upd_range;
                state_next = (upd_range[31:24] == 8'h00) ? S_NORM : S_IDLE;
            end
            S_END:
            begin
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res_data.last = 1'b1;
                    held_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        // shift steps; a waiting result goes out first, stall if no room
        if (st_active && !(need_push && res_full))
        begin
            res_push      = need_push;
            res_data.last = !st_out;
            range_next    = st_range;
            if (st_shift)
            begin
                low_next   = sh_low_new;
                cache_next = sh_cache_new;
                pend_next  = sh_pend_new;
            end
            else
            begin
                low_next = st_low_keep;
            end
            if (st_out)
            begin
                held_next     = sh_res;
                held_vld_next = 1'b1;
            end
            else if (st_final)
            begin
                held_vld_next = 1'b0;
            end
            n_next    = n_reg - 1'b1;
            step_next = step_reg + 1'b1;
            if (st_final)
            begin
                state_next = st_out ? S_END : S_IDLE;
                if (state_reg == S_FLUSH)
                begin
                    low_next   = '0;
                    range_next = RANGE_INIT;
                    cache_next = '0;
                    pend_next  = 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            low_reg      <= '0;
            range_reg    <= RANGE_INIT;
            cache_reg    <= '0;
            pend_reg     <= 32'd1;
            held_vld_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            low_reg      <= low_next;
            range_reg    <= range_next;
            cache_reg    <= cache_next;
            pend_reg     <= pend_next;
            held_vld_reg <= held_vld_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg  <= held_next;
        bound_reg <= bound_next;
        bit_reg   <= bit_next;
        dir_reg   <= dir_next;
        n_reg     <= n_next;
    end

endmodule

`default_nettype wire

// File: hdl/lzma_range_encoder_top.sv
// Top level of the LZMA-style binary range encoder.
// Depends on lre_pkg, lre_fifo, lre_front and lre_back.
//
// Usage: input items enter through a queue interface (push/full) and carry
// a command: encode one bit under a probability (cmd 0), encode up to
// MAX_DIRECT_BITS direct bits MSB first (cmd 1), or flush and restart (cmd 2).
// Result items leave through a queue interface (empty/pop); each tells the
// caller one byte (first_byte) followed by run_length copies of run_byte.
// last marks the final result caused by an item; items releasing no bytes
// produce no result. Unknown commands and zero-length direct groups are
// accepted and dropped.
// Timing: a two-entry command queue feeds the engine, which fetches items in
// S_IDLE. A modeled bit is an update plus its byte shifts (normally 0 to 2);
// direct bits take one step per bit; a flush is 5 byte shifts. An end step
// (S_END) follows when the final shift of an item releases bytes. The byte
// shift (one per cycle while the result queue has room) sets the pace.
// Reset puts the coder into its initial state and empties both queues.
// When the receiver stalls, the two-entry result queue fills and the engine
// waits; the command queue keeps taking items until it is full.
`default_nettype none

module lzma_range_encoder_top
    import lre_pkg::*;
#(
    parameter int PROB_BITS       = PROB_BITS_DEF,
    parameter int MAX_DIRECT_BITS = MAX_DIRECT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic                 bit_value,
    input  wire logic [PROB_IN_W-1:0] prob,
    input  wire logic [DIR_W-1:0]     direct_bits,
    input  wire logic [NUM_IN_W-1:0]  dir_count,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                first_byte,
    output logic [31:0]               run_length,
    output logic [7:0]                run_byte,
    output logic                      last
);

    localparam int ENTRY_W = entry_width(PROB_BITS, MAX_DIRECT_BITS);

    logic               q_empty;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_data;
    logic               res_full;
    logic               res_push;
    res_t               res_in;
    res_t               res_out;

    lre_front #(
        .PROB_BITS       (PROB_BITS),
        .MAX_DIRECT_BITS (MAX_DIRECT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .bit_value   (bit_value),
        .prob        (prob),
        .direct_bits (direct_bits),
        .dir_count   (dir_count),
        .q_pop       (q_pop),
        .q_empty     (q_empty),
        .q_data      (q_data)
    );

    lre_back #(
        .PROB_BITS       (PROB_BITS),
        .MAX_DIRECT_BITS (MAX_DIRECT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_in)
    );

    // result queue decouples the engine from the receiver
    lre_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign first_byte = res_out.first_byte;
    assign run_length = res_out.run_length;
    assign run_byte   = res_out.run_byte;
    assign last       = res_out.last;

    // engine never writes a result into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written while result queue full");

    // engine only fetches when a command is queued
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command fetched from empty queue");

    // a written result is visible to the receiver next cycle
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("written result not visible");

endmodule

`default_nettype wire
